// File: rtl/core/ccsr_pkg.sv
// Shared types, constants and codes for the character canvas shape rasterizer.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package ccsr_pkg;

	// Canvas geometry.
	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int ROW_IW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_IW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DIM_W      = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);

	// Field widths.
	localparam int CFG_W   = 7;
	localparam int RAD_W   = 7;
	localparam int SQ_W    = 2 * RAD_W;
	localparam int GLYPH_W = 8;
	// Scan coordinates reach from -255 (center minus radius) to +254.
	localparam int COORD_W = 10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_W-1:0]   RESET_ROWS = 7'd64;
	localparam logic [CFG_W-1:0]   RESET_COLS = 7'd64;
	localparam logic [GLYPH_W-1:0] BLANK      = 8'h20;

	typedef enum logic [2:0] {
		KIND_CLEAR     = 3'd0,
		KIND_POINT     = 3'd1,
		KIND_CIRC_OUT  = 3'd2,
		KIND_CIRC_FILL = 3'd3,
		KIND_RECT_OUT  = 3'd4,
		KIND_RECT_FILL = 3'd5,
		KIND_READ      = 3'd6
	} cmd_kind_t;

	typedef enum logic {
		REG_ROWS_IN_USE = 1'b0,
		REG_COLS_IN_USE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [7:0]  row_a;
		logic signed [7:0]  col_a;
		logic signed [7:0]  row_b;
		logic signed [7:0]  col_b;
		logic [RAD_W-1:0]   radius;
		logic [GLYPH_W-1:0] glyph;
	} cmd_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] cell_glyph;
		logic               clipped;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} dims_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		JOB_NONE = 2'd0,
		JOB_BOX  = 2'd1,
		JOB_DISC = 2'd2,
		JOB_READ = 2'd3
	} job_op_t;

	// One scan job: a box of cells, optionally masked by a disc test.
	typedef struct packed {
		job_op_t            op;
		logic               last;
		coord_t             r0;
		coord_t             r1;
		coord_t             c0;
		coord_t             c1;
		logic [RAD_W-1:0]   rad;
		logic [SQ_W-1:0]    rsq;
		logic [SQ_W-1:0]    isq;
		logic               inner_en;
		logic [GLYPH_W-1:0] glyph;
	} job_t;

	typedef enum logic {
		F_IDLE = 1'b0,
		F_EMIT = 1'b1
	} front_state_t;

	typedef enum logic [1:0] {
		B_INIT   = 2'd0,
		B_IDLE   = 2'd1,
		B_SCAN   = 2'd2,
		B_RESULT = 2'd3
	} back_state_t;

endpackage

// File: rtl/core/ccsr_front.sv
// Front end: takes command items and breaks each into one or more scan jobs.
// Depends on ccsr_pkg.
`timescale 1ns / 1ps

module ccsr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             enable,
	input  ccsr_pkg::dims_t  dims,
	input  logic             in_valid,
	output logic             in_ready,
	input  ccsr_pkg::cmd_t   in_data,
	output logic             job_valid,
	input  logic             job_ready,
	output ccsr_pkg::job_t   job
);

	ccsr_pkg::front_state_t state_q, state_d;
	ccsr_pkg::cmd_t         item_q;
	logic [1:0]             phase_q;

	ccsr_pkg::coord_t ra, ca, rb, cb, rad_c, rm1_c, one_c;
	logic [ccsr_pkg::RAD_W-1:0] rm1;
	logic                       job_push;

	assign job_push = job_valid && job_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccsr_pkg::F_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = ccsr_pkg::F_EMIT;
				end
			end
			ccsr_pkg::F_EMIT: begin
				if (job_push && job.last) begin
					state_d = ccsr_pkg::F_IDLE;
				end
			end
			default: state_d = ccsr_pkg::F_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_ready  = enable && (state_q == ccsr_pkg::F_IDLE);
		job_valid = (state_q == ccsr_pkg::F_EMIT);
	end

	// Decode the held command into the job for the current phase.
	always_comb begin
		ra    = ccsr_pkg::coord_t'(item_q.row_a);
		ca    = ccsr_pkg::coord_t'(item_q.col_a);
		rb    = ccsr_pkg::coord_t'(item_q.row_b);
		cb    = ccsr_pkg::coord_t'(item_q.col_b);
		one_c = ccsr_pkg::coord_t'(1);
		rad_c = ccsr_pkg::coord_t'(item_q.radius);
		rm1   = item_q.radius - ccsr_pkg::RAD_W'(1);
		rm1_c = ccsr_pkg::coord_t'(rm1);

		job          = '0;
		job.op       = ccsr_pkg::JOB_NONE;
		job.last     = 1'b1;
		job.glyph    = item_q.glyph;
		job.inner_en = 1'b0;

		unique case (item_q.kind)
			ccsr_pkg::KIND_CLEAR: begin
				job.op    = ccsr_pkg::JOB_BOX;
				job.r0    = '0;
				job.r1    = ccsr_pkg::coord_t'(dims.rows) - one_c;
				job.c0    = '0;
				job.c1    = ccsr_pkg::coord_t'(dims.cols) - one_c;
				job.glyph = ccsr_pkg::BLANK;
			end
			ccsr_pkg::KIND_POINT: begin
				job.op = ccsr_pkg::JOB_BOX;
				job.r0 = ra;
				job.r1 = ra;
				job.c0 = ca;
				job.c1 = ca;
			end
			ccsr_pkg::KIND_CIRC_OUT: begin
				// Outer disc gets the glyph, the disc one smaller is blanked.
				job.op       = ccsr_pkg::JOB_DISC;
				job.r0       = ra - rad_c;
				job.r1       = ra + rad_c;
				job.c0       = ca - rad_c;
				job.c1       = ca + rad_c;
				job.rad      = item_q.radius;
				job.rsq      = ccsr_pkg::SQ_W'(item_q.radius) * ccsr_pkg::SQ_W'(item_q.radius);
				job.isq      = ccsr_pkg::SQ_W'(rm1) * ccsr_pkg::SQ_W'(rm1);
				job.inner_en = (item_q.radius != '0);
			end
			ccsr_pkg::KIND_CIRC_FILL: begin
				if (item_q.radius != '0) begin
					job.op  = ccsr_pkg::JOB_DISC;
					job.r0  = ra - rm1_c;
					job.r1  = ra + rm1_c;
					job.c0  = ca - rm1_c;
					job.c1  = ca + rm1_c;
					job.rad = rm1;
					job.rsq = ccsr_pkg::SQ_W'(rm1) * ccsr_pkg::SQ_W'(rm1);
				end
			end
			ccsr_pkg::KIND_RECT_OUT: begin
				job.op   = ccsr_pkg::JOB_BOX;
				job.last = (phase_q == 2'd3);
				unique case (phase_q)
					2'd0: begin
						job.r0 = ra;
						job.r1 = ra;
						job.c0 = ca;
						job.c1 = cb;
					end
					2'd1: begin
						job.r0 = rb;
						job.r1 = rb;
						job.c0 = ca;
						job.c1 = cb;
					end
					2'd2: begin
						job.r0 = ra;
						job.r1 = rb;
						job.c0 = cb;
						job.c1 = cb;
					end
					default: begin
						job.r0 = ra;
						job.r1 = rb;
						job.c0 = ca;
						job.c1 = ca;
					end
				endcase
			end
			ccsr_pkg::KIND_RECT_FILL: begin
				job.op = ccsr_pkg::JOB_BOX;
				job.r0 = ra + one_c;
				job.r1 = rb - one_c;
				job.c0 = ca + one_c;
				job.c1 = cb - one_c;
			end
			ccsr_pkg::KIND_READ: begin
				job.op = ccsr_pkg::JOB_READ;
				job.r0 = ra;
				job.r1 = ra;
				job.c0 = ca;
				job.c1 = ca;
			end
			default: begin
				job.op = ccsr_pkg::JOB_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccsr_pkg::F_IDLE;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				phase_q <= '0;
			end else if (job_push) begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
	end

endmodule

// File: rtl/core/ccsr_queue.sv
// Short job queue between the front end and the scan engine.
// Depends on ccsr_pkg.
`timescale 1ns / 1ps

module ccsr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ccsr_pkg::job_t push_data,
	output logic           head_valid,
	input  logic           pop,
	output ccsr_pkg::job_t head
);

	ccsr_pkg::job_t              entry_q [ccsr_pkg::QUEUE_DEPTH];
	logic [ccsr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ccsr_pkg::QPTR_W:0]   count_q;
	logic                        do_push, do_pop;

	assign push_ready = (count_q != (ccsr_pkg::QPTR_W + 1)'(ccsr_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + ccsr_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + ccsr_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (ccsr_pkg::QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (ccsr_pkg::QPTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/ccsr_back.sv
// Scan engine: owns the canvas memory, walks each job one cell per cycle and
// builds the result item. Depends on ccsr_pkg.
`timescale 1ns / 1ps

module ccsr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ccsr_pkg::dims_t   dims,
	input  logic              job_valid,
	input  ccsr_pkg::job_t    job,
	output logic              job_pop,
	output logic              init_done,
	output logic              out_valid,
	input  logic              out_ready,
	output ccsr_pkg::result_t out_data
);

	ccsr_pkg::back_state_t state_q, state_d;

	logic [ccsr_pkg::GLYPH_W-1:0] canvas_mem [ccsr_pkg::CELL_COUNT];
	logic [ccsr_pkg::GLYPH_W-1:0] rdata_q;
	logic [ccsr_pkg::ADDR_W-1:0]  init_cnt_q;

	// Working registers of the job being scanned.
	ccsr_pkg::coord_t             i_q, j_q, r1_q, c0_q, c1_q, dr_q, dc_q, nrad_q;
	logic [ccsr_pkg::SQ_W-1:0]    dr2_q, dc2_q, rsq_q, isq_q;
	logic                         inner_q, disc_q, last_q;
	logic [ccsr_pkg::GLYPH_W-1:0] glyph_q;

	logic              clip_q, rd_sel_q, out_valid_q;
	ccsr_pkg::result_t out_q;

	logic                         head_empty, head_in, cell_in, hit, row_end, box_end;
	logic [ccsr_pkg::SQ_W:0]      dsq;
	logic [ccsr_pkg::GLYPH_W-1:0] cell_val;
	ccsr_pkg::coord_t             dr_step, dc_step;

	logic                         mem_we, rd_en, out_load, clip_set;
	logic [ccsr_pkg::ADDR_W-1:0]  mem_addr, rd_addr;
	logic [ccsr_pkg::GLYPH_W-1:0] mem_wdata;

	function automatic logic cell_inside(ccsr_pkg::coord_t r, ccsr_pkg::coord_t c,
			ccsr_pkg::dims_t d);
		return (r >= 0) && (c >= 0) && (r < ccsr_pkg::coord_t'(d.rows))
			&& (c < ccsr_pkg::coord_t'(d.cols));
	endfunction

	function automatic logic [ccsr_pkg::ADDR_W-1:0] cell_addr(ccsr_pkg::coord_t r,
			ccsr_pkg::coord_t c);
		return ccsr_pkg::ADDR_W'(r[ccsr_pkg::ROW_IW-1:0]) * ccsr_pkg::ADDR_W'(ccsr_pkg::MAX_COLS)
			+ ccsr_pkg::ADDR_W'(c[ccsr_pkg::COL_IW-1:0]);
	endfunction

	// Cell test. Squared distances are tracked incrementally, so no multiply
	// sits in the scan path.
	always_comb begin
		head_empty = (job.r0 > job.r1) || (job.c0 > job.c1);
		head_in    = cell_inside(job.r0, job.c0, dims);
		cell_in    = cell_inside(i_q, j_q, dims);
		dsq        = {1'b0, dr2_q} + {1'b0, dc2_q};
		hit        = !disc_q || (dsq <= {1'b0, rsq_q});
		cell_val   = (disc_q && inner_q && (dsq <= {1'b0, isq_q})) ? ccsr_pkg::BLANK : glyph_q;
		row_end    = (j_q == c1_q);
		box_end    = row_end && (i_q == r1_q);
		dr_step    = (dr_q <<< 1) + ccsr_pkg::coord_t'(1);
		dc_step    = (dc_q <<< 1) + ccsr_pkg::coord_t'(1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccsr_pkg::B_INIT: begin
				if (init_cnt_q == ccsr_pkg::ADDR_W'(ccsr_pkg::CELL_COUNT - 1)) begin
					state_d = ccsr_pkg::B_IDLE;
				end
			end
			ccsr_pkg::B_IDLE: begin
				if (job_valid) begin
					unique case (job.op)
						ccsr_pkg::JOB_BOX, ccsr_pkg::JOB_DISC: begin
							if (!head_empty) begin
								state_d = ccsr_pkg::B_SCAN;
							end else if (job.last) begin
								state_d = ccsr_pkg::B_RESULT;
							end
						end
						default: state_d = ccsr_pkg::B_RESULT;
					endcase
				end
			end
			ccsr_pkg::B_SCAN: begin
				if (box_end) begin
					state_d = last_q ? ccsr_pkg::B_RESULT : ccsr_pkg::B_IDLE;
				end
			end
			ccsr_pkg::B_RESULT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ccsr_pkg::B_IDLE;
				end
			end
			default: state_d = ccsr_pkg::B_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		init_done = (state_q != ccsr_pkg::B_INIT);
		job_pop   = (state_q == ccsr_pkg::B_IDLE) && job_valid;
		rd_en     = job_pop && (job.op == ccsr_pkg::JOB_READ) && head_in;
		rd_addr   = cell_addr(job.r0, job.c0);
		out_load  = (state_q == ccsr_pkg::B_RESULT) && (!out_valid_q || out_ready);
		clip_set  = ((state_q == ccsr_pkg::B_SCAN) && hit && !cell_in)
			|| (job_pop && (job.op == ccsr_pkg::JOB_READ) && !head_in);
		if (state_q == ccsr_pkg::B_INIT) begin
			mem_we    = 1'b1;
			mem_addr  = init_cnt_q;
			mem_wdata = ccsr_pkg::BLANK;
		end else begin
			mem_we    = (state_q == ccsr_pkg::B_SCAN) && hit && cell_in;
			mem_addr  = cell_addr(i_q, j_q);
			mem_wdata = cell_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ccsr_pkg::B_INIT;
			init_cnt_q  <= '0;
			clip_q      <= 1'b0;
			rd_sel_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ccsr_pkg::B_INIT) begin
				init_cnt_q <= init_cnt_q + ccsr_pkg::ADDR_W'(1);
			end
			if (out_load) begin
				clip_q <= 1'b0;
			end else if (clip_set) begin
				clip_q <= 1'b1;
			end
			if (job_pop) begin
				rd_sel_q <= rd_en;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Scan datapath.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			i_q     <= job.r0;
			j_q     <= job.c0;
			r1_q    <= job.r1;
			c0_q    <= job.c0;
			c1_q    <= job.c1;
			nrad_q  <= ccsr_pkg::coord_t'(0) - ccsr_pkg::coord_t'(job.rad);
			dr_q    <= ccsr_pkg::coord_t'(0) - ccsr_pkg::coord_t'(job.rad);
			dc_q    <= ccsr_pkg::coord_t'(0) - ccsr_pkg::coord_t'(job.rad);
			dr2_q   <= job.rsq;
			dc2_q   <= job.rsq;
			rsq_q   <= job.rsq;
			isq_q   <= job.isq;
			inner_q <= job.inner_en;
			disc_q  <= (job.op == ccsr_pkg::JOB_DISC);
			glyph_q <= job.glyph;
			last_q  <= job.last;
		end else if (state_q == ccsr_pkg::B_SCAN) begin
			if (row_end) begin
				i_q   <= i_q + ccsr_pkg::coord_t'(1);
				j_q   <= c0_q;
				dr_q  <= dr_q + ccsr_pkg::coord_t'(1);
				dr2_q <= dr2_q + ccsr_pkg::SQ_W'(dr_step);
				dc_q  <= nrad_q;
				dc2_q <= rsq_q;
			end else begin
				j_q   <= j_q + ccsr_pkg::coord_t'(1);
				dc_q  <= dc_q + ccsr_pkg::coord_t'(1);
				dc2_q <= dc2_q + ccsr_pkg::SQ_W'(dc_step);
			end
		end
		if (out_load) begin
			out_q.cell_glyph <= rd_sel_q ? rdata_q : '0;
			out_q.clipped    <= clip_q;
		end
	end

	// Canvas memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			canvas_mem[mem_addr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= canvas_mem[rd_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/core/char_canvas_shape_rasterizer.sv
// Character canvas shape rasterizer, top level: size registers, front end,
// job queue and scan engine. Depends on ccsr_pkg, ccsr_front, ccsr_queue, ccsr_back.
// Each item scans N cells, N being: rows*cols for a clear, (2r+1)^2 for a circle outline,
// (2r-1)^2 for a filled circle, the interior area for a rectangle fill, one for a point,
// none for a read, kind 7 or an empty shape. A rectangle outline scans 2(w+h) cells in
// four jobs. Throughput: the single write port sets one cell per cycle while a job is
// scanned. After reset the canvas is swept to spaces; no item is taken then.
`timescale 1ns / 1ps

module char_canvas_shape_rasterizer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ccsr_pkg::cmd_t               in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ccsr_pkg::result_t            out_data,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [ccsr_pkg::CFG_W-1:0]   cfg_data
);

	// Size registers as written; change them only while idle. The block does not enforce this.
	logic [ccsr_pkg::CFG_W-1:0] rows_q, cols_q;
	ccsr_pkg::dims_t            dims;

	// Front end to queue, and queue to scan engine.
	logic           fq_valid, fq_ready;
	ccsr_pkg::job_t fq_job;
	logic           head_valid, head_pop;
	ccsr_pkg::job_t head_job;
	logic           init_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ccsr_pkg::RESET_ROWS;
			cols_q <= ccsr_pkg::RESET_COLS;
		end else if (cfg_we) begin
			if (cfg_index == ccsr_pkg::REG_ROWS_IN_USE) begin
				rows_q <= cfg_data;
			end
			if (cfg_index == ccsr_pkg::REG_COLS_IN_USE) begin
				cols_q <= cfg_data;
			end
		end
	end

	// A size above the canvas limit acts as the limit itself.
	always_comb begin
		dims.rows = (int'(rows_q) > ccsr_pkg::MAX_ROWS) ? ccsr_pkg::DIM_W'(ccsr_pkg::MAX_ROWS)
			: ccsr_pkg::DIM_W'(rows_q);
		dims.cols = (int'(cols_q) > ccsr_pkg::MAX_COLS) ? ccsr_pkg::DIM_W'(ccsr_pkg::MAX_COLS)
			: ccsr_pkg::DIM_W'(cols_q);
	end

	// The front end holds one command item and emits its jobs; a rectangle outline
	// becomes four single-line jobs, every other command one job.
	ccsr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (init_done),
		.dims      (dims),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	// The queue lets the front end decode the next item while the engine scans.
	ccsr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_job),
		.head_valid (head_valid),
		.pop        (head_pop),
		.head       (head_job)
	);

	// The engine writes the canvas, gathers the clipped flag over all jobs of an
	// item and hands the result to an output register that waits for out_ready.
	ccsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims),
		.job_valid (head_valid),
		.job       (head_job),
		.job_pop   (head_pop),
		.init_done (init_done),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
